>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLKRST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLKRST(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

>>> rtl/core/dpqhf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dpqhf_pkg;

  localparam logic [2:0] REQ_PROTECT   = 3'd0;
  localparam logic [2:0] REQ_FLUSH_ALL = 3'd1;
  localparam logic [2:0] REQ_FLUSH_ADR = 3'd2;
  localparam logic [2:0] REQ_FLUSH_RNG = 3'd3;
  localparam logic [2:0] REQ_FLUSH_TAG = 3'd4;

  localparam logic [2:0] MODE_RW = 3'd2;
  localparam logic [2:0] MODE_WX = 3'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [47:0] range_start;
    logic [47:0] range_length;
    logic [2:0]  access_mode;
    logic [31:0] req_tag;
  } req_t;

  typedef struct packed {
    logic [47:0] cmd_start;
    logic [47:0] cmd_length;
    logic [2:0]  cmd_mode;
    logic        last_of_run;
  } cmd_t;

  typedef enum logic [2:0] {
    OPK_NONE, OPK_EMIT, OPK_PUSH, OPK_DRAIN, OPK_OVERLAP, OPK_TAG
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [47:0] start;
    logic [47:0] len;
    logic [48:0] end_addr;
    logic        zero;
    logic [2:0]  mode;
    logic [31:0] tag;
    logic        emit_self;
  } op_t;

  typedef struct packed {
    logic [47:0] start;
    logic [47:0] len;
    logic [48:0] end_addr;
    logic        zero;
    logic [2:0]  mode;
    logic [31:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_SCAN, BK_DRAIN, BK_EMIT, BK_PUSH
  } bk_state_t;

endpackage
`default_nettype wire

>>> rtl/core/dpqhf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dpqhf_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  dpqhf_pkg::req_t  req,
  input  wire              bypass,
  output logic             op_valid,
  output dpqhf_pkg::op_t   op_out,
  input  wire              op_pop
);
  import dpqhf_pkg::*;

  op_t        fifo [2];
  logic       wp, rp;
  logic [1:0] fcnt;
  op_t        op_c;
  logic       push;

  // classify the request
  always_comb begin
    op_c           = '0;
    op_c.kind      = OPK_NONE;
    op_c.start     = req.range_start;
    op_c.len       = req.range_length;
    op_c.mode      = req.access_mode;
    op_c.tag       = req.req_tag;
    op_c.zero      = (req.range_length == '0);
    op_c.end_addr  = {1'b0, req.range_start} + {1'b0, req.range_length} - 49'd1;
    op_c.emit_self = 1'b0;
    unique case (req.req_type)
      REQ_PROTECT: begin
        if (bypass) begin
          op_c.kind = OPK_EMIT;
        end else if (req.access_mode == MODE_RW || req.access_mode == MODE_WX) begin
          op_c.kind      = OPK_OVERLAP;
          op_c.emit_self = 1'b1;
        end else begin
          op_c.kind = OPK_PUSH;
        end
      end
      REQ_FLUSH_ALL: op_c.kind = OPK_DRAIN;
      REQ_FLUSH_ADR: begin
        op_c.kind     = OPK_OVERLAP;
        op_c.zero     = 1'b0;
        op_c.end_addr = {1'b0, req.range_start};
      end
      REQ_FLUSH_RNG: op_c.kind = OPK_OVERLAP;
      REQ_FLUSH_TAG: op_c.kind = OPK_TAG;
      default:       op_c.kind = OPK_NONE;
    endcase
  end

  assign busy     = (fcnt == 2'd2);
  assign push     = start && !busy && (op_c.kind != OPK_NONE);
  assign op_valid = (fcnt != 2'd0);
  assign op_out   = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fcnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (op_pop) rp <= ~rp;
      fcnt <= fcnt + {1'b0, push} - {1'b0, op_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= op_c;
  end

endmodule
`default_nettype wire

>>> rtl/core/dpqhf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dpqhf_back #(
  parameter int QUEUE_DEPTH = 16,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              op_valid,
  input  dpqhf_pkg::op_t   op_in,
  output logic             op_pop,
  output logic             idle,
  output logic [CNT_W-1:0] count,
  output logic             cmd_valid,
  output dpqhf_pkg::cmd_t  cmd
);
  import dpqhf_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  entry_t wdata;
  logic   mem_we, rd_en;
  logic [PTR_W-1:0] rd_addr, tail;

  bk_state_t state, state_next;
  op_t op, op_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count_next, idx, idx_next, tally, tally_next;
  logic [CNT_W-1:0] k, k_next, sent, sent_next, ocnt, ocnt_next;
  logic cmpv, cmpv_next, pend, pend_next;
  logic emit_after, emit_after_next, push_after, push_after_next;
  logic cmd_valid_next;
  cmd_t cmd_next;
  logic hit, decided;
  logic [CNT_W-1:0] dk;

  function automatic logic [PTR_W-1:0] wrap_add(logic [PTR_W-1:0] a, logic [CNT_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic entry_t to_entry(op_t o);
    entry_t e;
    e.start    = o.start;
    e.len      = o.len;
    e.end_addr = o.end_addr;
    e.zero     = o.zero;
    e.mode     = o.mode;
    e.tag      = o.tag;
    return e;
  endfunction

  function automatic bk_state_t after_drain(logic ea, logic pa);
    bk_state_t s;
    s = BK_IDLE;
    if (ea) s = BK_EMIT;
    else if (pa) s = BK_PUSH;
    return s;
  endfunction

  assign tail  = wrap_add(head, count);
  assign idle  = (state == BK_IDLE);
  assign wdata = (state == BK_IDLE) ? to_entry(op_in) : to_entry(op);
  assign hit   = !rd_data.zero && !op.zero &&
                 ({1'b0, rd_data.start} <= op.end_addr) &&
                 ({1'b0, op.start} <= rd_data.end_addr);

  always_comb begin
    state_next      = state;
    op_next         = op;
    head_next       = head;
    count_next      = count;
    idx_next        = idx;
    tally_next      = tally;
    k_next          = k;
    sent_next       = sent;
    ocnt_next       = ocnt;
    cmpv_next       = 1'b0;
    pend_next       = 1'b0;
    emit_after_next = emit_after;
    push_after_next = push_after;
    cmd_valid_next  = 1'b0;
    cmd_next        = cmd;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head;
    op_pop          = 1'b0;
    decided         = 1'b0;
    dk              = '0;
    unique case (state)
      BK_IDLE: begin
        if (op_valid) begin
          op_pop          = 1'b1;
          op_next         = op_in;
          emit_after_next = op_in.emit_self;
          push_after_next = 1'b0;
          idx_next        = '0;
          tally_next      = '0;
          sent_next       = '0;
          ocnt_next       = '0;
          k_next          = count;
          unique case (op_in.kind)
            OPK_EMIT: begin
              cmd_valid_next = 1'b1;
              cmd_next = '{op_in.start, op_in.len, op_in.mode, 1'b1};
            end
            OPK_PUSH: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                // full: drain everything, then queue
                push_after_next = 1'b1;
                emit_after_next = 1'b0;
                state_next      = BK_DRAIN;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OPK_DRAIN: begin
              emit_after_next = 1'b0;
              if (count != '0) state_next = BK_DRAIN;
            end
            OPK_OVERLAP, OPK_TAG: state_next = BK_SCAN;
            default: ;
          endcase
        end
      end
      BK_SCAN: begin
        if (cmpv) begin
          if (op.kind == OPK_OVERLAP) begin
            if (hit) begin
              decided = 1'b1;
              dk      = count;
            end
          end else if (rd_data.tag > op.tag) begin
            decided = 1'b1;
            dk      = tally;
          end else begin
            tally_next = tally + CNT_W'(1);
          end
        end
        if (!decided) begin
          if (!cmpv && idx == count) begin
            if (op.kind == OPK_OVERLAP) begin
              state_next = op.emit_self ? BK_EMIT : BK_IDLE;
            end else begin
              decided = 1'b1;
              dk      = tally;
            end
          end else if (idx != count) begin
            rd_en     = 1'b1;
            rd_addr   = wrap_add(head, idx);
            idx_next  = idx + CNT_W'(1);
            cmpv_next = 1'b1;
          end
        end
        if (decided) begin
          k_next    = dk;
          sent_next = '0;
          ocnt_next = '0;
          cmpv_next = 1'b0;
          state_next = (dk == '0) ? after_drain(emit_after, push_after) : BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (sent != k) begin
          rd_en     = 1'b1;
          rd_addr   = wrap_add(head, sent);
          sent_next = sent + CNT_W'(1);
          pend_next = 1'b1;
        end
        if (pend) begin
          cmd_valid_next = 1'b1;
          cmd_next = '{rd_data.start, rd_data.len, rd_data.mode,
                       (ocnt + CNT_W'(1) == k) && !emit_after};
          ocnt_next = ocnt + CNT_W'(1);
          if (ocnt + CNT_W'(1) == k) begin
            head_next  = wrap_add(head, k);
            count_next = count - k;
            pend_next  = 1'b0;
            state_next = after_drain(emit_after, push_after);
          end
        end
      end
      BK_EMIT: begin
        cmd_valid_next = 1'b1;
        cmd_next   = '{op.start, op.len, op.mode, 1'b1};
        state_next = BK_IDLE;
      end
      BK_PUSH: begin
        mem_we     = 1'b1;
        count_next = count + CNT_W'(1);
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      head      <= '0;
      count     <= '0;
      cmpv      <= 1'b0;
      pend      <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      cmpv      <= cmpv_next;
      pend      <= pend_next;
      cmd_valid <= cmd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    idx        <= idx_next;
    tally      <= tally_next;
    k          <= k_next;
    sent       <= sent_next;
    ocnt       <= ocnt_next;
    emit_after <= emit_after_next;
    push_after <= push_after_next;
    cmd        <= cmd_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[tail] <= wdata;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/core/deferred_protect_queue_hazard_flush_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A queued protect passes the op FIFO and is written to the queue with no command;
// a full queue drains first. A bypassed protect passes the op FIFO and strobes its
// registered command. Scans read one queue entry per cycle, drains emit one command
// per cycle. Throughput: one transaction per cycle for queued (queue not full) and
// bypassed protects; scans and drains stall input once the 2-entry op FIFO fills.
// The result strobe cannot be stalled. Reset (rst, synchronous) empties queue and FIFO.
module deferred_protect_queue_hazard_flush_unit #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  dpqhf_pkg::req_t  req,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire              cfg_data,
  output logic             cmd_valid,
  output dpqhf_pkg::cmd_t  cmd
);
  import dpqhf_pkg::*;
  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             bypass_queue;
  logic             op_valid, op_pop, back_idle;
  op_t              op;
  logic [CNT_W-1:0] count;

  // config: always ready; the user must write it only while the unit is idle (unchecked)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass_queue <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      bypass_queue <= cfg_data;
    end
  end

  // front: accept and classify, hold ops in a short FIFO
  dpqhf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .bypass   (bypass_queue),
    .op_valid (op_valid),
    .op_out   (op),
    .op_pop   (op_pop)
  );

  // back: entry memory, hazard scans, drains and emits
  dpqhf_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_in     (op),
    .op_pop    (op_pop),
    .idle      (back_idle),
    .count     (count),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !cmd_valid)
  `ASSERT_CLKRST(a_count_bound, clk, rst, count <= CNT_W'(QUEUE_DEPTH))
  `ASSERT_CLKRST(a_cmd_has_source, clk, rst, cmd_valid |-> $past(!back_idle || op_valid))

endmodule
`default_nettype wire
